### design/vn_pkg.sv
// Shared types and constants for the vector3_normalize pipeline.
// No dependencies; used by vn_front, vn_cell and the top level.
package vn_pkg;

  localparam int unsigned CompW    = 32;   // input and output component width
  localparam int unsigned SumW     = 64;   // squared length, Q32.32
  localparam int unsigned QBits    = 31;   // unit magnitude bits, at most 2^30
  localparam int unsigned AccW     = 130;  // signed remainder and cross term
  localparam int unsigned NumCells = 31;   // one cell per quotient bit
  localparam int unsigned BitW     = 5;
  localparam int unsigned NumLanes = 3;

  localparam logic [CompW-1:0] ThrReset = 32'd256;

  typedef struct packed {
    logic signed [AccW-1:0] rem;  // mag^2 * 2^62 - o^2 * S
    logic signed [AccW-1:0] us;   // o * S, with o = 2q - 1
    logic [QBits-1:0]       q;
    logic                   neg;
  } vn_lane_t;

  typedef struct packed {
    logic                   valid;
    logic                   ok;
    logic [SumW-1:0]        s;
    vn_lane_t [NumLanes-1:0] lane;
  } vn_stage_t;

endpackage

### design/vector3_normalize.sv
// Top level of the 3D vector normalizer: front end, a row of bit cells, output register.
// Depends on vn_pkg, vn_front and vn_cell.
//
//   channel   direction  fields
//   s_axis    in         tdata = vec_x, vec_y, vec_z
//   m_axis    out        tdata = unit_x, unit_y, unit_z; tuser = ok
//   cfg       in         data = near_zero_sq_threshold
//
// One vector per cycle while the output is not stalled; the stages are three front
// stages, one cell per quotient bit (31), and the output register.
// All stages advance together; a stalled output holds the whole pipeline.
// Reset clears the valid bits and sets the threshold to 256.
module vector3_normalize (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // vec_x, vec_y, vec_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // unit_x, unit_y, unit_z
  output logic [0:0]  m_axis_tuser,   // ok
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic en;
  logic [31:0] thr_q;
  vn_pkg::vn_stage_t chain [vn_pkg::NumCells+1];
  logic        out_valid_q;
  logic        out_ok_q;
  logic [95:0] out_data_q, out_data_d;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= vn_pkg::ThrReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  vn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .vec_i   (s_axis_tdata),
    .thr_i   (thr_q),
    .stage_o (chain[0])
  );

  for (genvar k = 0; k < vn_pkg::NumCells; k++) begin : g_cell
    vn_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .bit_i   (vn_pkg::BitW'(vn_pkg::NumCells - 1 - k)),
      .stage_i (chain[k]),
      .stage_o (chain[k+1])
    );
  end

  // apply sign, force zero on near-zero length
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [31:0] m;
      m = {1'b0, chain[vn_pkg::NumCells].lane[i].q};
      if (!chain[vn_pkg::NumCells].ok) begin
        out_data_d[i*32 +: 32] = '0;
      end else if (chain[vn_pkg::NumCells].lane[i].neg) begin
        out_data_d[i*32 +: 32] = ~m + 1'b1;
      end else begin
        out_data_d[i*32 +: 32] = m;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain[vn_pkg::NumCells].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_ok_q   <= chain[vn_pkg::NumCells].ok;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ok_q;

endmodule

### design/vn_front.sv
// Front end: magnitudes, squares, sum of squares and near-zero test.
// Depends on vn_pkg; feeds the first vn_cell of the chain.
module vn_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [3*vn_pkg::CompW-1:0]      vec_i,
  input  logic [vn_pkg::CompW-1:0]        thr_i,
  output vn_pkg::vn_stage_t               stage_o
);

  logic [2:0]                    va_q, va_d;
  logic [vn_pkg::CompW-1:0]      mag_q [3];
  logic [vn_pkg::CompW-1:0]      mag_d [3];
  logic [2:0]                    neg_a_q, neg_b_q;
  logic [vn_pkg::SumW-1:0]       sq_q [3];
  logic [vn_pkg::CompW-1:0]      thr_b_q;
  logic [vn_pkg::SumW-1:0]       sum_c;
  vn_pkg::vn_stage_t             stage_q, stage_d;

  assign va_d = {va_q[1:0], valid_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [vn_pkg::CompW-1:0] c;
      c = vec_i[i*vn_pkg::CompW +: vn_pkg::CompW];
      mag_d[i] = c[vn_pkg::CompW-1] ? (~c + 1'b1) : c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
    end else if (en_i) begin
      va_q <= va_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i]   <= mag_d[i];
        neg_a_q[i] <= vec_i[i*vn_pkg::CompW + vn_pkg::CompW - 1];
        sq_q[i]    <= vn_pkg::SumW'(mag_q[i]) * vn_pkg::SumW'(mag_q[i]);
      end
      neg_b_q <= neg_a_q;
      thr_b_q <= thr_i;
    end
  end

  // S <= 3 * 2^62, so the sum never carries out of 64 bits
  assign sum_c = sq_q[0] + sq_q[1] + sq_q[2];

  always_comb begin
    stage_d.valid = va_q[1];
    stage_d.ok    = sum_c > {32'd0, thr_b_q};
    stage_d.s     = sum_c;
    for (int i = 0; i < 3; i++) begin
      stage_d.lane[i].rem = $signed({4'd0, sq_q[i], 62'd0}) - $signed({66'd0, sum_c});
      stage_d.lane[i].us  = -$signed({66'd0, sum_c});
      stage_d.lane[i].q   = '0;
      stage_d.lane[i].neg = neg_b_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

### design/vn_cell.sv
// One cell of the inverse square root chain: decides one quotient bit per lane.
// Depends on vn_pkg; instantiated in a row by vector3_normalize.
module vn_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [vn_pkg::BitW-1:0]  bit_i,
  input  vn_pkg::vn_stage_t        stage_i,
  output vn_pkg::vn_stage_t        stage_o
);

  vn_pkg::vn_stage_t stage_q, stage_d;
  logic signed [vn_pkg::AccW-1:0] s_ext;
  logic [6:0] sh1, sh2, sh3;

  assign s_ext = $signed({66'd0, stage_i.s});
  assign sh1   = {2'd0, bit_i} + 7'd1;
  assign sh2   = {2'd0, bit_i} + 7'd2;
  assign sh3   = {1'b0, bit_i, 1'b0} + 7'd2;

  // Setting bit b grows o by 2^(b+1): o^2*S grows by 2^(b+2)*o*S + 2^(2b+2)*S
  always_comb begin
    stage_d = stage_i;
    for (int i = 0; i < 3; i++) begin
      logic signed [vn_pkg::AccW-1:0] delta;
      delta = (stage_i.lane[i].us <<< sh2) + (s_ext <<< sh3);
      if (!stage_i.lane[i].q[vn_pkg::QBits-1] && (delta <= stage_i.lane[i].rem)) begin
        stage_d.lane[i].rem       = stage_i.lane[i].rem - delta;
        stage_d.lane[i].us        = stage_i.lane[i].us + (s_ext <<< sh1);
        stage_d.lane[i].q[bit_i]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule
